@@ design/sst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the step segment tracker
// Request opcodes, sequencer states, phase codes and distance constants.
// ----------------------------------------------------------------------------
package sst_pkg;

    // request opcodes
    typedef enum logic [1:0] {
        OP_WRITE_SEG = 2'd0,
        OP_BIND      = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_PROGRESS  = 2'd3
    } t_op;

    // step phase codes
    localparam logic [1:0] PH_NONE      = 2'd0;
    localparam logic [1:0] PH_PREPARING = 2'd1;
    localparam logic [1:0] PH_ARMED     = 2'd2;
    localparam logic [1:0] PH_COMMITTED = 2'd3;

    // capability values above this one map onto it
    localparam logic [1:0] CAP_MAX = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_HOLD_CHK,
        S_WALK,
        S_REL,
        S_PREP,
        S_PH_COMMIT,
        S_PH_ACTIVE,
        S_ENTER,
        S_ADJ,
        S_RND,
        S_DIV,
        S_OUT
    } t_state;

    // mm to cm: (x + 5) / 10, clamped to 255
    localparam int          DIST_ROUND   = 5;
    localparam int          DIST_CLAMP   = 2560;   // first x + 5 giving more than 255
    localparam int          DIV_IN_BITS  = 12;     // x + 5 below the clamp fits here
    localparam int          RECIP_BITS   = 13;
    localparam int          RECIP_SHIFT  = 16;
    localparam int          PROD_BITS    = DIV_IN_BITS + RECIP_BITS;
    localparam logic [12:0] RECIP_10     = 13'd6554; // ceil(2^16 / 10)
    localparam logic [7:0]  DIST_MAX     = 8'd255;

endpackage

@@ design/sst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 123,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sst_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_alu: shared add / subtract and sign test
// Computes a + b or a - b and flags a non-negative or positive result.
// ----------------------------------------------------------------------------
module sst_alu #(
    parameter int W = 26
) (
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    input  logic                i_sub,
    output logic signed [W-1:0] o_sum,
    output logic                o_ge,
    output logic                o_pos
);

    logic signed [W-1:0] b_op;

    always_comb begin
        b_op  = i_sub ? ~i_b : i_b;
        o_sum = i_a + b_op + W'(i_sub);
        o_ge  = ~o_sum[W-1];
        o_pos = ~o_sum[W-1] & (|o_sum);
    end

endmodule

@@ design/step_segment_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_segment_tracker: step segment table and progress tracker
// Holds step segments, follows path progress and reports the step phase.
// ----------------------------------------------------------------------------
// usage
//   requests enter on start when busy is low. op write segment, bind path and
//   clear path finish at the accepting edge and give no result; the next
//   request may follow in the very next cycle.
//   a progress update gives one result on o_strobe for a single cycle. with no
//   path bound it comes in the cycle after the request. otherwise busy stays
//   high while one shared adder walks the table: a release check of a held
//   segment; if none is held or it is released, one table read and one compare
//   per table entry the walk reads, then a step to end the walk or test the
//   prepare mark; then, once a segment is held, the commit and active phase
//   tests and the enter, offset, round, divide and output steps, some of which
//   are skipped or end the request early. the strobe comes in the first cycle
//   with busy low again, so the next request may be accepted in that same cycle.
//   the single table read port and the single adder set how long busy lasts.
//   the receiver cannot stall: each result must be taken in its strobe cycle.
//   i_cfg_we writes the signed step offset in mm; write it only while idle.
//   reset clears path binding, held segment and offset; the segment table is
//   not cleared and an entry must be written before a bound path reads it.
// ----------------------------------------------------------------------------
module step_segment_tracker #(
    parameter int MAX_SEGMENTS = 16,
    parameter int ARC_BITS     = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_seg_index,
    input  logic [23:0] i_prepare_mm,
    input  logic [23:0] i_active_mm,
    input  logic [23:0] i_commit_mm,
    input  logic [23:0] i_enter_mm,
    input  logic [23:0] i_release_mm,
    input  logic [1:0]  i_capability,
    input  logic        i_is_step,
    input  logic [4:0]  i_seg_count,
    input  logic [23:0] i_progress_mm,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // result channel
    output logic        o_strobe,
    output logic [1:0]  o_phase,
    output logic        o_seg_valid,
    output logic [3:0]  o_seg_out_index,
    output logic [1:0]  o_target_profile,
    output logic [7:0]  o_step_distance_cm
);

    // table index width and counter width (counter can hold MAX_SEGMENTS)
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int A  = ARC_BITS;
    localparam int W  = ARC_BITS + 2;   // signed width of all differences

    // table entry layout
    localparam int PREP_LSB = 0;
    localparam int ACT_LSB  = A;
    localparam int COM_LSB  = 2 * A;
    localparam int ENT_LSB  = 3 * A;
    localparam int REL_LSB  = 4 * A;
    localparam int KIND_LSB = 5 * A;
    localparam int EW       = 5 * A + 3;

    // control state
    sst_pkg::t_state r_state, n_state;
    logic           r_bound, n_bound;
    logic [CW-1:0]  r_total, n_total;
    logic [CW-1:0]  r_next, n_next;
    logic           r_held_valid, n_held_valid;
    logic [IW-1:0]  r_held, n_held;
    logic [CW-1:0]  r_idx, n_idx;
    logic signed [15:0] r_offset;
    logic           r_strobe, n_strobe;

    // payload
    logic [A-1:0]        r_prog, n_prog;
    logic [1:0]          r_phase, n_phase;
    logic signed [W-1:0] r_acc, n_acc;
    logic                r_clamp, n_clamp;
    logic [sst_pkg::PROD_BITS-1:0] r_prod, n_prod;
    logic [1:0]  r_o_phase, n_o_phase;
    logic        r_o_valid, n_o_valid;
    logic [3:0]  r_o_index, n_o_index;
    logic [1:0]  r_o_prof, n_o_prof;
    logic [7:0]  r_o_dist, n_o_dist;

    // table port
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    // shared adder
    logic signed [W-1:0] alu_a, alu_b, alu_sum;
    logic                alu_sub, alu_ge, alu_pos;

    logic          accept;
    logic          seg_ok;
    logic [CW-1:0] count_sat;
    logic [IW+3:0] wa_ext;
    logic [IW+3:0] held_ext;
    logic [3:0]    held_idx4;
    logic [1:0]    cap, prof;
    logic          is_step;
    logic signed [W-1:0] prog_s;

    assign accept = start & ~busy;
    assign busy   = (r_state != sst_pkg::S_IDLE);

    // write address: only entries inside the table are written
    assign wa_ext    = {{IW{1'b0}}, i_seg_index};
    assign ram_waddr = wa_ext[IW-1:0];
    assign seg_ok    = 32'(i_seg_index) < 32'(MAX_SEGMENTS);
    assign ram_wdata = {i_is_step, i_capability, A'(i_release_mm), A'(i_enter_mm),
                        A'(i_commit_mm), A'(i_active_mm), A'(i_prepare_mm)};

    // bound path length saturates at the table depth
    assign count_sat = (32'(i_seg_count) > 32'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS)
                                                              : CW'(i_seg_count);

    // held entry view
    assign held_ext  = {4'b0000, r_held};
    assign held_idx4 = held_ext[3:0];
    assign cap       = ram_rdata[KIND_LSB +: 2];
    assign is_step   = ram_rdata[KIND_LSB + 2];
    assign prof      = (cap > sst_pkg::CAP_MAX) ? (sst_pkg::CAP_MAX + 2'd1) : (cap + 2'd1);
    assign prog_s    = $signed({2'b00, r_prog});

    sst_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sst_alu #(
        .W (W)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum),
        .o_ge  (alu_ge),
        .o_pos (alu_pos)
    );

    always_comb begin
        n_state      = r_state;
        n_bound      = r_bound;
        n_total      = r_total;
        n_next       = r_next;
        n_held_valid = r_held_valid;
        n_held       = r_held;
        n_idx        = r_idx;
        n_strobe     = 1'b0;
        n_prog       = r_prog;
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_clamp      = r_clamp;
        n_prod       = r_prod;
        n_o_phase    = r_o_phase;
        n_o_valid    = r_o_valid;
        n_o_index    = r_o_index;
        n_o_prof     = r_o_prof;
        n_o_dist     = r_o_dist;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_idx[IW-1:0];
        alu_a        = prog_s;
        alu_b        = '0;
        alu_sub      = 1'b1;

        case (r_state)
            sst_pkg::S_IDLE: begin
                if (accept) begin
                    case (sst_pkg::t_op'(i_op))
                        sst_pkg::OP_WRITE_SEG: begin
                            ram_we = seg_ok;
                        end
                        sst_pkg::OP_BIND: begin
                            n_bound      = 1'b1;
                            n_total      = count_sat;
                            n_next       = '0;
                            n_held_valid = 1'b0;
                        end
                        sst_pkg::OP_CLEAR: begin
                            n_bound      = 1'b0;
                            n_total      = '0;
                            n_next       = '0;
                            n_held_valid = 1'b0;
                        end
                        sst_pkg::OP_PROGRESS: begin
                            n_prog = A'(i_progress_mm);
                            if (!r_bound) begin
                                // no path: report nothing
                                n_next       = '0;
                                n_held_valid = 1'b0;
                                n_strobe     = 1'b1;
                                n_o_phase    = sst_pkg::PH_NONE;
                                n_o_valid    = 1'b0;
                                n_o_index    = '0;
                                n_o_prof     = '0;
                                n_o_dist     = '0;
                            end else if (r_held_valid) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_held;
                                n_state   = sst_pkg::S_HOLD_CHK;
                            end else begin
                                n_idx   = r_next;
                                n_state = sst_pkg::S_WALK;
                            end
                        end
                        default: begin
                            n_state = sst_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            sst_pkg::S_HOLD_CHK: begin
                // release the held segment once progress reaches its release mark
                alu_b = $signed({2'b00, ram_rdata[REL_LSB +: A]});
                if (alu_ge) begin
                    n_held_valid = 1'b0;
                    n_idx        = CW'(r_held) + CW'(1);
                    n_state      = sst_pkg::S_WALK;
                end else begin
                    n_state = sst_pkg::S_PH_COMMIT;
                end
            end

            sst_pkg::S_WALK: begin
                if (r_idx >= r_total) begin
                    n_next    = r_idx;
                    n_strobe  = 1'b1;
                    n_o_phase = sst_pkg::PH_NONE;
                    n_o_valid = 1'b0;
                    n_o_index = '0;
                    n_o_prof  = '0;
                    n_o_dist  = '0;
                    n_state   = sst_pkg::S_IDLE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = sst_pkg::S_REL;
                end
            end

            sst_pkg::S_REL: begin
                // skip segments already released
                alu_b = $signed({2'b00, ram_rdata[REL_LSB +: A]});
                if (alu_ge) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = sst_pkg::S_WALK;
                end else begin
                    n_next  = r_idx;
                    n_state = sst_pkg::S_PREP;
                end
            end

            sst_pkg::S_PREP: begin
                // first unreleased segment: acquire it if its prepare mark is reached
                alu_b = $signed({2'b00, ram_rdata[PREP_LSB +: A]});
                if (alu_ge) begin
                    n_held_valid = 1'b1;
                    n_held       = r_idx[IW-1:0];
                    n_state      = sst_pkg::S_PH_COMMIT;
                end else begin
                    n_strobe  = 1'b1;
                    n_o_phase = sst_pkg::PH_NONE;
                    n_o_valid = 1'b0;
                    n_o_index = '0;
                    n_o_prof  = '0;
                    n_o_dist  = '0;
                    n_state   = sst_pkg::S_IDLE;
                end
            end

            sst_pkg::S_PH_COMMIT: begin
                alu_b = $signed({2'b00, ram_rdata[COM_LSB +: A]});
                if (!is_step) begin
                    // non-step segment only selects the profile
                    n_strobe  = 1'b1;
                    n_o_phase = sst_pkg::PH_NONE;
                    n_o_valid = 1'b0;
                    n_o_index = '0;
                    n_o_prof  = prof;
                    n_o_dist  = '0;
                    n_state   = sst_pkg::S_IDLE;
                end else if (alu_ge) begin
                    n_phase = sst_pkg::PH_COMMITTED;
                    n_state = sst_pkg::S_ENTER;
                end else begin
                    n_state = sst_pkg::S_PH_ACTIVE;
                end
            end

            sst_pkg::S_PH_ACTIVE: begin
                alu_b   = $signed({2'b00, ram_rdata[ACT_LSB +: A]});
                n_phase = alu_ge ? sst_pkg::PH_ARMED : sst_pkg::PH_PREPARING;
                n_state = sst_pkg::S_ENTER;
            end

            sst_pkg::S_ENTER: begin
                // enter - progress, zero distance once entry is reached
                alu_a = $signed({2'b00, ram_rdata[ENT_LSB +: A]});
                alu_b = prog_s;
                if (alu_pos) begin
                    n_acc   = alu_sum;
                    n_state = sst_pkg::S_ADJ;
                end else begin
                    n_strobe  = 1'b1;
                    n_o_phase = r_phase;
                    n_o_valid = 1'b1;
                    n_o_index = held_idx4;
                    n_o_prof  = prof;
                    n_o_dist  = '0;
                    n_state   = sst_pkg::S_IDLE;
                end
            end

            sst_pkg::S_ADJ: begin
                alu_a   = r_acc;
                alu_b   = W'(r_offset);
                alu_sub = 1'b0;
                if (alu_pos) begin
                    n_acc   = alu_sum;
                    n_state = sst_pkg::S_RND;
                end else begin
                    n_strobe  = 1'b1;
                    n_o_phase = r_phase;
                    n_o_valid = 1'b1;
                    n_o_index = held_idx4;
                    n_o_prof  = prof;
                    n_o_dist  = '0;
                    n_state   = sst_pkg::S_IDLE;
                end
            end

            sst_pkg::S_RND: begin
                alu_a   = r_acc;
                alu_b   = W'(sst_pkg::DIST_ROUND);
                alu_sub = 1'b0;
                n_acc   = alu_sum;
                n_state = sst_pkg::S_DIV;
            end

            sst_pkg::S_DIV: begin
                // divide by ten through the reciprocal, exact below the clamp
                n_clamp = (r_acc >= W'(sst_pkg::DIST_CLAMP));
                n_prod  = sst_pkg::PROD_BITS'(r_acc[sst_pkg::DIV_IN_BITS-1:0])
                        * sst_pkg::PROD_BITS'(sst_pkg::RECIP_10);
                n_state = sst_pkg::S_OUT;
            end

            sst_pkg::S_OUT: begin
                n_strobe  = 1'b1;
                n_o_phase = r_phase;
                n_o_valid = 1'b1;
                n_o_index = held_idx4;
                n_o_prof  = prof;
                n_o_dist  = r_clamp ? sst_pkg::DIST_MAX : r_prod[sst_pkg::RECIP_SHIFT +: 8];
                n_state   = sst_pkg::S_IDLE;
            end

            default: begin
                n_state = sst_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sst_pkg::S_IDLE;
            r_bound      <= 1'b0;
            r_total      <= '0;
            r_next       <= '0;
            r_held_valid <= 1'b0;
            r_held       <= '0;
            r_idx        <= '0;
            r_offset     <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bound      <= n_bound;
            r_total      <= n_total;
            r_next       <= n_next;
            r_held_valid <= n_held_valid;
            r_held       <= n_held;
            r_idx        <= n_idx;
            r_strobe     <= n_strobe;
            if (i_cfg_we) begin
                r_offset <= $signed(i_cfg_wdata);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prog    <= n_prog;
        r_phase   <= n_phase;
        r_acc     <= n_acc;
        r_clamp   <= n_clamp;
        r_prod    <= n_prod;
        r_o_phase <= n_o_phase;
        r_o_valid <= n_o_valid;
        r_o_index <= n_o_index;
        r_o_prof  <= n_o_prof;
        r_o_dist  <= n_o_dist;
    end

    assign o_strobe           = r_strobe;
    assign o_phase            = r_o_phase;
    assign o_seg_valid        = r_o_valid;
    assign o_seg_out_index    = r_o_index;
    assign o_target_profile   = r_o_prof;
    assign o_step_distance_cm = r_o_dist;

    // only a progress request on a bound path makes the tracker busy
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && (i_op == sst_pkg::OP_PROGRESS) && r_bound))
        else $error("busy rose without a progress request on a bound path");

    // a held segment always lies inside the bound path
    a_held_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (CW'(r_held) < r_total))
        else $error("held segment outside the bound path");

    // the walk position never passes the path length
    a_next_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= r_total)
        else $error("next segment beyond path length");

    // an observed step segment always reports a phase
    a_valid_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_seg_valid) |-> (o_phase != sst_pkg::PH_NONE))
        else $error("step segment reported without phase");

    // no observed segment means no index, phase or distance
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_seg_valid) |->
            (o_seg_out_index == 4'd0 && o_step_distance_cm == 8'd0 &&
             o_phase == sst_pkg::PH_NONE))
        else $error("fields set without an observed step segment");

endmodule
